[src/nsr_pkg.sv]
// Shared types and character constants for the numeric string recognizer.
package nsr_pkg;

    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_UPR_A = 8'h41;
    localparam logic [7:0] CHAR_UPR_F = 8'h46;
    localparam logic [7:0] CHAR_LWR_A = 8'h61;
    localparam logic [7:0] CHAR_LWR_E = 8'h65;
    localparam logic [7:0] CHAR_LWR_F = 8'h66;
    localparam logic [7:0] CHAR_LWR_X = 8'h78;

    typedef enum logic [10:0] {
        PH_SPACE     = 11'b000_0000_0001,
        PH_ZERO      = 11'b000_0000_0010,
        PH_INT       = 11'b000_0000_0100,
        PH_FRAC      = 11'b000_0000_1000,
        PH_EXP_MARK  = 11'b000_0001_0000,
        PH_EXP_SIGN  = 11'b000_0010_0000,
        PH_EXP_DIGIT = 11'b000_0100_0000,
        PH_HEX       = 11'b000_1000_0000,
        PH_REJECT    = 11'b001_0000_0000,
        PH_ENDED_YES = 11'b010_0000_0000,
        PH_ENDED_NO  = 11'b100_0000_0000
    } phase_t;

    typedef struct packed {
        logic nul;
        logic ws;
        logic dec;
        logic hex;
        logic zero;
        logic sign;
        logic dot;
        logic exp_e;
        logic hex_x;
    } char_class_t;

endpackage

[src/numeric_string_recognizer.sv]
// Numeric string recognizer: top level with input and result registers.
//
// Text enters one byte per transfer on the input channel (char_code, last_byte,
// in_valid/in_stall). A zero byte ends the text; bytes after it are ignored. An
// empty text is a single zero byte with last_byte set.
// For the byte marked last, one verdict leaves on the output channel
// (numeric_verdict, out_valid/out_stall): 1 when the text is a numeric string
// (leading whitespace, then 0x plus any hex digits, or a signed decimal with optional
// fraction and lowercase e exponent). Other bytes produce no output transfer.
// A last byte sits in the input register, then its verdict in the result register.
// Throughput: one byte per clock unless stalled; the phase updates once per byte.
// When the receiver stalls, the verdict holds in the result register; bytes that
// are not last keep flowing, and a following last byte waits in the input
// register, raising in_stall until the result register frees up.
// Reset clears both valid flags and returns the parser to leading whitespace.
module numeric_string_recognizer (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] char_code,
    input  logic       last_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       numeric_verdict
);
    import nsr_pkg::*;

    logic        s1_valid_reg, s1_valid_next;
    logic [7:0]  s1_char_reg;
    logic        s1_last_reg;
    logic        out_valid_reg, out_valid_next;
    logic        verdict_reg;
    logic        s1_go;
    logic        in_take;
    logic        verdict;
    char_class_t cls;

    // a byte that is not last needs no result slot
    assign s1_go    = s1_valid_reg && (!s1_last_reg || !out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !s1_go;
    assign in_take  = in_valid && !in_stall;

    nsr_classify u_classify (
        .char_code (s1_char_reg),
        .cls       (cls)
    );

    nsr_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (s1_go),
        .cls     (cls),
        .last_in (s1_last_reg),
        .verdict (verdict)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_take)
            s1_valid_next = 1'b1;
        else if (s1_go)
            s1_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (s1_go && s1_last_reg)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_char_reg <= char_code;
            s1_last_reg <= last_byte;
        end
        if (s1_go && s1_last_reg)
            verdict_reg <= verdict;
    end

    assign out_valid       = out_valid_reg;
    assign numeric_verdict = verdict_reg;

endmodule

[src/nsr_classify.sv]
// Character class decode for one text byte.
module nsr_classify (
    input  logic [7:0]          char_code,
    output nsr_pkg::char_class_t cls
);
    import nsr_pkg::*;

    logic is_dec;

    assign is_dec = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);

    always_comb
    begin
        cls.nul   = (char_code == CHAR_NUL);
        cls.ws    = (char_code == CHAR_SPACE)
                    || ((char_code >= CHAR_TAB) && (char_code <= CHAR_CR));
        cls.dec   = is_dec;
        cls.hex   = is_dec
                    || ((char_code >= CHAR_LWR_A) && (char_code <= CHAR_LWR_F))
                    || ((char_code >= CHAR_UPR_A) && (char_code <= CHAR_UPR_F));
        cls.zero  = (char_code == CHAR_ZERO);
        cls.sign  = (char_code == CHAR_PLUS) || (char_code == CHAR_MINUS);
        cls.dot   = (char_code == CHAR_DOT);
        cls.exp_e = (char_code == CHAR_LWR_E);
        cls.hex_x = (char_code == CHAR_LWR_X);
    end

endmodule

[src/nsr_parser.sv]
// Parse phase register, next-phase logic and end-of-text verdict.
module nsr_parser (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step_en,
    input  nsr_pkg::char_class_t cls,
    input  logic                 last_in,
    output logic                 verdict
);
    import nsr_pkg::*;

    phase_t phase_reg, phase_next, phase_upd;
    logic   seen_reg, seen_next, seen_upd;

    function automatic logic end_ok(input phase_t ph, input logic seen);
        logic ok;
        ok = 1'b0;
        unique case (ph)
            PH_ZERO, PH_EXP_DIGIT, PH_HEX, PH_ENDED_YES: ok = 1'b1;
            PH_INT, PH_FRAC:                             ok = seen;
            default:                                     ok = 1'b0;
        endcase
        return ok;
    endfunction

    always_comb
    begin
        phase_upd = phase_reg;
        seen_upd  = seen_reg;
        if ((phase_reg != PH_ENDED_YES) && (phase_reg != PH_ENDED_NO))
        begin
            if (cls.nul)
            begin
                phase_upd = end_ok(phase_reg, seen_reg) ? PH_ENDED_YES : PH_ENDED_NO;
            end
            else
            begin
                phase_upd = PH_REJECT;
                unique case (phase_reg)
                    PH_SPACE:
                    begin
                        priority if (cls.ws) phase_upd = PH_SPACE;
                        else if (cls.zero)
                        begin
                            seen_upd  = 1'b1;
                            phase_upd = PH_ZERO;
                        end
                        else if (cls.dec)
                        begin
                            seen_upd  = 1'b1;
                            phase_upd = PH_INT;
                        end
                        else if (cls.sign) phase_upd = PH_INT;
                        else if (cls.dot)  phase_upd = PH_FRAC;
                        else               phase_upd = PH_REJECT;
                    end
                    PH_ZERO:
                    begin
                        priority if (cls.hex_x) phase_upd = PH_HEX;
                        else if (cls.dec)   phase_upd = PH_INT;
                        else if (cls.dot)   phase_upd = PH_FRAC;
                        else if (cls.exp_e) phase_upd = PH_EXP_MARK;
                        else                phase_upd = PH_REJECT;
                    end
                    PH_INT, PH_FRAC:
                    begin
                        priority if (cls.dec)
                        begin
                            seen_upd  = 1'b1;
                            phase_upd = phase_reg;
                        end
                        else if (cls.dot && (phase_reg == PH_INT)) phase_upd = PH_FRAC;
                        else if (cls.exp_e)
                        begin
                            // exponent only after at least one mantissa digit
                            phase_upd = seen_reg ? PH_EXP_MARK : PH_REJECT;
                        end
                        else phase_upd = PH_REJECT;
                    end
                    PH_EXP_MARK:
                    begin
                        priority if (cls.sign) phase_upd = PH_EXP_SIGN;
                        else if (cls.dec)  phase_upd = PH_EXP_DIGIT;
                        else               phase_upd = PH_REJECT;
                    end
                    PH_EXP_SIGN, PH_EXP_DIGIT:
                    begin
                        if (cls.dec) phase_upd = PH_EXP_DIGIT;
                    end
                    PH_HEX:
                    begin
                        if (cls.hex) phase_upd = PH_HEX;
                    end
                    default: phase_upd = PH_REJECT;
                endcase
            end
        end
    end

    assign verdict = end_ok(phase_upd, seen_upd);

    always_comb
    begin
        phase_next = phase_reg;
        seen_next  = seen_reg;
        if (step_en)
        begin
            // text done: back to the start for the next one
            phase_next = last_in ? PH_SPACE : phase_upd;
            seen_next  = last_in ? 1'b0 : seen_upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SPACE;
            seen_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            seen_reg  <= seen_next;
        end
    end

    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        step_en && last_in |=> (phase_reg == PH_SPACE) && !seen_reg)
        else $error("parser did not restart after last byte");

    a_zero_seen: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_ZERO) || (phase_reg == PH_EXP_MARK) |-> seen_reg)
        else $error("mantissa digit flag clear in a post-digit phase");

    a_ended_holds: assert property (@(posedge clk) disable iff (!rst_n)
        step_en && !last_in && (phase_reg == PH_ENDED_YES) |=> (phase_reg == PH_ENDED_YES))
        else $error("ended text changed phase");

    a_ended_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        step_en && (phase_reg == PH_ENDED_NO) |-> !verdict)
        else $error("rejected text gave a positive verdict");

endmodule
